### hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, register indexes and control structs of the Sobel edge
// magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int PIXEL_BITS_DEF  = 8;
  localparam int MAX_ROWS        = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 11;
  localparam int ROW_W     = 10;
  localparam int COLI_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 11'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic load_col;
    logic grad;
    logic second;
    logic sq_x;
    logic sq_y;
    logic root_step;
    logic put_out;
    logic put_last;
  } sem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic emit_a;
    logic emit_b;
    logic out_free;
  } sem_sts_t;

endpackage

### hw/rtl/sobel_edge_magnitude.sv
// A word that yields results passes through load, gradient, squaring, an
// iterative root and the output register for each result; the root unit
// produces one bit a cycle. A new word is taken only once the last one is done.
// Reset clears counters, window and configuration (1024 x 1024); line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude with replicated borders, built as a
// controller and a datapath.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_COLUMNS = sem_pkg::MAX_COLUMNS_DEF,
  parameter int PIXEL_BITS  = sem_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [PIXEL_BITS-1:0]         pixel_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sem_pkg::MAG_W-1:0]     edge_magnitude,
  output logic [sem_pkg::ROW_W-1:0]     row_index,
  output logic [sem_pkg::COLI_W-1:0]    col_index,
  output logic                          last_of_item,
  output logic                          frame_end
);
  import sem_pkg::*;

  sem_cmd_t cmd;
  sem_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  sem_ctrl #(.PIXEL_BITS(PIXEL_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sem_dp #(.MAX_COLUMNS(MAX_COLUMNS), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .pixel_value    (pixel_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .edge_magnitude (edge_magnitude),
    .row_index      (row_index),
    .col_index      (col_index),
    .last_of_item   (last_of_item),
    .frame_end      (frame_end),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### hw/rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: takes one word, updates the window, then works each result
// through gradient, squaring, an iterative root and the output register.
// ----------------------------------------------------------------------------
module sem_ctrl #(
  parameter int PIXEL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sem_pkg::sem_sts_t sts,
  output sem_pkg::sem_cmd_t cmd
);
  import sem_pkg::*;

  localparam int RT_W   = PIXEL_BITS + 3;
  localparam int STEP_W = $clog2(RT_W);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_CHOOSE, S_GRAD, S_SQX, S_SQY, S_ROOT, S_PUT
  } state_t;

  state_t            state;
  logic              second;
  logic [STEP_W-1:0] step;

  assign in_ready = (state == S_IDLE);

  // Commands decoded from the state.
  always_comb begin
    cmd           = '0;
    cmd.second    = second;
    cmd.take_item = (state == S_IDLE) && in_valid && sts.match;
    cmd.load_col  = (state == S_LOAD);
    cmd.grad      = (state == S_GRAD);
    cmd.sq_x      = (state == S_SQX);
    cmd.sq_y      = (state == S_SQY);
    cmd.root_step = (state == S_ROOT);
    cmd.put_out   = (state == S_PUT) && sts.out_free;
    cmd.put_last  = second || !sts.emit_b;
  end

  // State register and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      step   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && sts.match) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_CHOOSE;
        end
        S_CHOOSE: begin
          priority if (sts.emit_a) begin
            second <= 1'b0;
            state  <= S_GRAD;
          end else if (sts.emit_b) begin
            second <= 1'b1;
            state  <= S_GRAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_GRAD: begin
          state <= S_SQX;
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          step  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(RT_W - 1)) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (sts.out_free) begin
            if (!second && sts.emit_b) begin
              second <= 1'b1;
              state  <= S_GRAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sem_dp.sv
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: configuration registers, raster counters, two line stores, the
// 3x3 window, gradient and squaring stages, a bit-pair root unit and the
// output register.
// ----------------------------------------------------------------------------
module sem_dp #(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             op,
  input  logic [PIXEL_BITS-1:0]            pixel_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [sem_pkg::MAG_W-1:0]        edge_magnitude,
  output logic [sem_pkg::ROW_W-1:0]        row_index,
  output logic [sem_pkg::COLI_W-1:0]       col_index,
  output logic                             last_of_item,
  output logic                             frame_end,
  input  sem_pkg::sem_cmd_t                cmd,
  output sem_pkg::sem_sts_t                sts
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int GRD_W = PIXEL_BITS + 3;
  localparam int ABS_W = PIXEL_BITS + 2;
  localparam int RT_W  = PIXEL_BITS + 3;
  localparam int SQ_W  = 2 * RT_W;

  logic [CFG_W-1:0]      frame_columns;
  logic [CFG_W-1:0]      frame_rows;
  logic [COL_W-1:0]      column_count;
  logic [ROW_W-1:0]      row_count;
  logic                  draining;
  logic [PIXEL_BITS-1:0] pix_in;
  logic [PIXEL_BITS-1:0] win_t [3];
  logic [PIXEL_BITS-1:0] win_m [3];
  logic [PIXEL_BITS-1:0] win_b [3];
  logic [COL_W-1:0]      cur_col;
  logic [ROW_W-1:0]      cur_row;
  logic                  cur_drain;
  logic                  emit_a;
  logic                  emit_b;
  logic [ABS_W-1:0]      ax;
  logic [ABS_W-1:0]      ay;
  logic [SQ_W-1:0]       acc;
  logic [RT_W:0]         rem;
  logic [RT_W-1:0]       root;

  logic [PIXEL_BITS-1:0] up_rd;
  logic [PIXEL_BITS-1:0] mid_rd;
  logic                  emits;
  logic [ROW_W-1:0]      crow;
  logic [PIXEL_BITS-1:0] top_px;
  logic [PIXEL_BITS-1:0] bot_px;
  logic [31:0]           w_eff;
  logic [CFG_W-1:0]      h_eff;
  logic                  lastcol;
  logic                  lastrow;
  logic [1:0]            lidx;
  logic [1:0]            cidx;
  logic [GRD_W-1:0]      sx_pos;
  logic [GRD_W-1:0]      sx_neg;
  logic [GRD_W-1:0]      sy_pos;
  logic [GRD_W-1:0]      sy_neg;
  logic [GRD_W-1:0]      gx;
  logic [GRD_W-1:0]      gy;
  logic [GRD_W-1:0]      gx_abs;
  logic [GRD_W-1:0]      gy_abs;
  logic [ABS_W-1:0]      mul_op;
  logic [2*ABS_W-1:0]    prod;
  logic [RT_W+2:0]       cand;
  logic [RT_W+2:0]       trial;

  // Line stores: rows r-2 and r-1, read at the current column.
  sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_upper (
    .clk   (clk),
    .we    (cmd.load_col && !draining),
    .waddr (column_count),
    .wdata (mid_rd),
    .re    (cmd.take_item),
    .raddr (column_count),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_middle (
    .clk   (clk),
    .we    (cmd.load_col && !draining),
    .waddr (column_count),
    .wdata (pix_in),
    .re    (cmd.take_item),
    .raddr (column_count),
    .rdata (mid_rd)
  );

  // Clamped frame size and end-of-row and end-of-frame tests.
  always_comb begin
    if (frame_columns == '0) begin
      w_eff = 32'd1;
    end else if (32'(frame_columns) > 32'(MAX_COLUMNS)) begin
      w_eff = 32'(MAX_COLUMNS);
    end else begin
      w_eff = 32'(frame_columns);
    end
    if (frame_rows == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_rows > CFG_W'(MAX_ROWS)) begin
      h_eff = CFG_W'(MAX_ROWS);
    end else begin
      h_eff = frame_rows;
    end
    lastcol = (32'(column_count) + 32'd1) >= w_eff;
    lastrow = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;
  end

  // New window column, with the top and bottom replicated at frame edges.
  always_comb begin
    emits  = draining || (row_count != '0);
    crow   = draining ? row_count : row_count - 1'b1;
    top_px = (emits && crow == '0) ? mid_rd : up_rd;
    bot_px = draining ? mid_rd : pix_in;
  end

  // Gradients over the selected window columns; the right one is the newest.
  always_comb begin
    if (cmd.second) begin
      lidx = (cur_col != '0) ? 2'd1 : 2'd2;
      cidx = 2'd2;
    end else begin
      lidx = (cur_col == COL_W'(1)) ? 2'd1 : 2'd0;
      cidx = 2'd1;
    end
    sx_pos = GRD_W'(win_t[2]) + (GRD_W'(win_m[2]) << 1) + GRD_W'(win_b[2]);
    sx_neg = GRD_W'(win_t[lidx]) + (GRD_W'(win_m[lidx]) << 1) + GRD_W'(win_b[lidx]);
    sy_pos = GRD_W'(win_t[lidx]) + (GRD_W'(win_t[cidx]) << 1) + GRD_W'(win_t[2]);
    sy_neg = GRD_W'(win_b[lidx]) + (GRD_W'(win_b[cidx]) << 1) + GRD_W'(win_b[2]);
    gx     = sx_pos - sx_neg;
    gy     = sy_pos - sy_neg;
    gx_abs = gx[GRD_W-1] ? -gx : gx;
    gy_abs = gy[GRD_W-1] ? -gy : gy;
  end

  // One shared squarer and one root step.
  always_comb begin
    mul_op = cmd.sq_x ? ax : ay;
    prod   = mul_op * mul_op;
    cand   = {rem, acc[SQ_W-1 -: 2]};
    trial  = (RT_W+3)'({root, 2'b01});
  end

  assign sts.match    = (op == draining);
  assign sts.emit_a   = emit_a;
  assign sts.emit_b   = emit_b;
  assign sts.out_free = !out_valid || out_ready;

  // Control registers: configuration, counters, window, emit flags and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_columns <= COLUMNS_RESET;
      frame_rows    <= ROWS_RESET;
      column_count  <= '0;
      row_count     <= '0;
      draining      <= 1'b0;
      emit_a        <= 1'b0;
      emit_b        <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_t[i] <= '0;
        win_m[i] <= '0;
        win_b[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_COLUMNS) begin
          frame_columns <= cfg_data;
        end
        if (cfg_index == REG_ROWS) begin
          frame_rows <= cfg_data;
        end
      end
      if (cmd.load_col) begin
        for (int i = 0; i < 2; i++) begin
          win_t[i] <= win_t[i+1];
          win_m[i] <= win_m[i+1];
          win_b[i] <= win_b[i+1];
        end
        win_t[2] <= top_px;
        win_m[2] <= mid_rd;
        win_b[2] <= bot_px;
        emit_a   <= emits && (column_count != '0);
        emit_b   <= emits && lastcol;
        if (lastcol) begin
          column_count <= '0;
          priority if (draining) begin
            draining  <= 1'b0;
            row_count <= '0;
          end else if (lastrow) begin
            draining <= 1'b1;
          end else begin
            row_count <= row_count + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
      if (cmd.put_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      pix_in <= pixel_value;
    end
    if (cmd.load_col) begin
      cur_col   <= column_count;
      cur_row   <= crow;
      cur_drain <= draining;
    end
    if (cmd.grad) begin
      ax <= ABS_W'(gx_abs);
      ay <= ABS_W'(gy_abs);
    end
    if (cmd.sq_x) begin
      acc  <= SQ_W'(prod);
      rem  <= '0;
      root <= '0;
    end
    if (cmd.sq_y) begin
      acc <= acc + SQ_W'(prod);
    end
    if (cmd.root_step) begin
      acc <= acc << 2;
      if (cand >= trial) begin
        rem  <= (RT_W+1)'(cand - trial);
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= (RT_W+1)'(cand);
        root <= {root[RT_W-2:0], 1'b0};
      end
    end
    if (cmd.put_out) begin
      edge_magnitude <= MAG_W'(root);
      row_index      <= cur_row;
      col_index      <= cmd.second ? COLI_W'(cur_col) : COLI_W'(cur_col - 1'b1);
      last_of_item   <= cmd.put_last;
      frame_end      <= cmd.second && cur_drain;
    end
  end

endmodule

### tb/sobel_edge_magnitude_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_checker
// Watches the register, pixel and result channels of the Sobel edge magnitude
// block. It keeps its own line stores and window, works out the edge results
// that each accepted input word should give, and compares them in order.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          op,
  input  logic [7:0]                    pixel_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sem_pkg::MAG_W-1:0]     edge_magnitude,
  input  logic [sem_pkg::ROW_W-1:0]     row_index,
  input  logic [sem_pkg::COLI_W-1:0]    col_index,
  input  logic                          last_of_item,
  input  logic                          frame_end,
  output int                            errors,
  output int                            pending
);
  import sem_pkg::*;

  typedef struct {
    logic [MAG_W-1:0]  mag;
    logic [ROW_W-1:0]  row;
    logic [COLI_W-1:0] col;
    logic              last;
    logic              fend;
  } edge_result_t;

  edge_result_t edge_queue[$];

  logic [7:0]  upper_line[MAX_COLUMNS_DEF];
  logic [7:0]  middle_line[MAX_COLUMNS_DEF];
  int          win[3][3];  // [column oldest..newest][row top..bottom]
  int          col_cnt;
  int          row_cnt;
  logic        draining;
  int          frame_cols;
  int          frame_rows;

  assign pending = edge_queue.size();

  // Integer floor square root.
  function automatic int root_floor(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Sobel magnitude over window columns lc, cc and rc.
  function automatic int sobel_mag(int lc, int cc, int rc);
    int gx, gy;
    gx = (win[rc][0] + 2 * win[rc][1] + win[rc][2])
       - (win[lc][0] + 2 * win[lc][1] + win[lc][2]);
    gy = (win[lc][0] + 2 * win[cc][0] + win[rc][0])
       - (win[lc][2] + 2 * win[cc][2] + win[rc][2]);
    return root_floor(gx * gx + gy * gy);
  endfunction

  // Advances the window by one word and queues the edge results it yields.
  task automatic predict_edges(logic flush, logic [7:0] pix);
    int           w, h, c, crow, t, m, b, n;
    logic         emits, lastcol;
    edge_result_t res[2];
    w = frame_cols < 1 ? 1 : (frame_cols > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : frame_cols);
    h = frame_rows < 1 ? 1 : (frame_rows > MAX_ROWS ? MAX_ROWS : frame_rows);
    n = 0;
    if (flush != draining) return;
    c = col_cnt % MAX_COLUMNS_DEF;
    emits = draining || row_cnt >= 1;
    crow = draining ? row_cnt : row_cnt - 1;
    m = int'(middle_line[c]);
    t = (emits && crow == 0) ? m : int'(upper_line[c]);
    b = draining ? m : int'(pix);
    for (int j = 0; j < 3; j++) begin
      win[0][j] = win[1][j];
      win[1][j] = win[2][j];
    end
    win[2][0] = t;
    win[2][1] = m;
    win[2][2] = b;
    if (!draining) begin
      upper_line[c] = 8'(m);
      middle_line[c] = pix;
    end
    lastcol = col_cnt + 1 >= w;
    if (emits && c >= 1) begin
      res[n] = '{MAG_W'(sobel_mag(c == 1 ? 1 : 0, 1, 2)), ROW_W'(crow), COLI_W'(c - 1),
                 1'b0, 1'b0};
      n++;
    end
    if (emits && lastcol) begin
      res[n] = '{MAG_W'(sobel_mag(c >= 1 ? 1 : 2, 2, 2)), ROW_W'(crow), COLI_W'(c),
                 1'b0, draining};
      n++;
    end
    for (int k = 0; k < n; k++) begin
      res[k].last = (k == n - 1);
      edge_queue.push_back(res[k]);
    end
    if (lastcol) begin
      col_cnt = 0;
      if (draining) begin
        draining = 1'b0;
        row_cnt = 0;
      end else if (row_cnt + 1 >= h) begin
        draining = 1'b1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endtask

  // Compares one accepted result word with the oldest expectation.
  task automatic check_edge();
    edge_result_t exp_res;
    if (edge_queue.size() == 0) begin
      $error("unexpected result word: magnitude %0d row %0d col %0d",
             edge_magnitude, row_index, col_index);
      errors++;
      return;
    end
    exp_res = edge_queue.pop_front();
    if (edge_magnitude !== exp_res.mag) begin
      $error("edge_magnitude: expected %0d, actual %0d", exp_res.mag, edge_magnitude);
      errors++;
    end
    if (row_index !== exp_res.row) begin
      $error("row_index: expected %0d, actual %0d", exp_res.row, row_index);
      errors++;
    end
    if (col_index !== exp_res.col) begin
      $error("col_index: expected %0d, actual %0d", exp_res.col, col_index);
      errors++;
    end
    if (last_of_item !== exp_res.last) begin
      $error("last_of_item: expected %0d, actual %0d", exp_res.last, last_of_item);
      errors++;
    end
    if (frame_end !== exp_res.fend) begin
      $error("frame_end: expected %0d, actual %0d", exp_res.fend, frame_end);
      errors++;
    end
  endtask

  // Sample all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = 0;
      for (int i = 0; i < MAX_COLUMNS_DEF; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      draining = 1'b0;
      frame_cols = int'(COLUMNS_RESET);
      frame_rows = int'(ROWS_RESET);
      edge_queue.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) check_edge();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COLUMNS) frame_cols = int'(cfg_data);
        else if (cfg_index == REG_ROWS) frame_rows = int'(cfg_data);
      end
      if (in_valid && in_ready) predict_edges(op, pixel_value);
    end
  end

endmodule

### tb/sobel_edge_magnitude_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_test
// Drives frames of gray pixels and flush words of many sizes through the
// Sobel edge magnitude block with random gaps and result stalls, and gives
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_test;
  import sem_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   STALL_LIMIT = 3000;
  localparam int   ITEM_TARGET = 700;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [7:0]           pixel_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [MAG_W-1:0]     edge_magnitude;
  logic [ROW_W-1:0]     row_index;
  logic [COLI_W-1:0]    col_index;
  logic                 last_of_item;
  logic                 frame_end;
  int                   errors;
  int                   pending;
  int                   item_count;
  int                   quiet_cycles;
  logic                 in_gaps;
  logic                 out_stalls;

  sobel_edge_magnitude DUT (.*);

  sobel_edge_magnitude_checker checker_i (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: a random stall before each result word.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = out_stalls ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on cycles with no accepted word on any channel.
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one input word; valid is only lowered for a gap before the word.
  task automatic send_word(logic kind, logic [7:0] pix);
    int gap;
    gap = in_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    pixel_value <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic wait_settled();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // One frame: pattern 0 random, 1 checkerboard, 2 vertical step.
  // Stray words of the wrong kind are mixed in and must be ignored.
  task automatic run_frame(int cols, int rows, int pattern);
    int         eff_cols, eff_rows;
    logic [7:0] pix;
    wait_settled();
    in_gaps = $urandom_range(0, 3) != 0;
    out_stalls = $urandom_range(0, 3) != 0;
    write_reg(REG_COLUMNS, CFG_W'(cols));
    write_reg(REG_ROWS, CFG_W'(rows));
    cfg_valid <= 1'b0;
    eff_cols = cols < 1 ? 1 : (cols > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : cols);
    eff_rows = rows < 1 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
    for (int r = 0; r < eff_rows; r++) begin
      for (int c = 0; c < eff_cols; c++) begin
        if ($urandom_range(0, 19) == 0) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
        case (pattern)
          1: pix = ((r + c) % 2) ? 8'd255 : 8'd0;
          2: pix = (c >= eff_cols / 2) ? 8'd255 : 8'd0;
          default: pix = 8'($urandom_range(0, 255));
        endcase
        send_word(OP_PIXEL, pix);
        item_count++;
      end
    end
    // Flush words drain the last row.
    for (int c = 0; c < eff_cols; c++) begin
      if ($urandom_range(0, 19) == 0) send_word(OP_PIXEL, 8'($urandom_range(0, 255)));
      send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
      item_count++;
    end
    in_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_PIXEL;
    pixel_value = '0;
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    item_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero sizes clamp to one, an unused register, hard edges.
    write_reg(REG_UNUSED, 11'h7FF);
    cfg_valid <= 1'b0;
    run_frame(0, 0, 0);
    run_frame(3, 3, 1);
    run_frame(4, 2, 2);
    run_frame(1, 3, 1);
    run_frame(3, 1, 1);

    // Random frames, mostly small.
    while (item_count < ITEM_TARGET)
      run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 2));

    wait_settled();
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
